@@ rtl/cvenc_pkg.sv @@
package cvenc_pkg;

    // field and register widths
    localparam int BYTE_W      = 8;
    localparam int KEY_IDX_W   = 7;
    localparam int MAX_KEY_LEN = 8;
    localparam int KEY_POS_W   = 3;
    localparam int KEY_LEN_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = MAX_KEY_LEN * KEY_IDX_W;

    // alphabet
    localparam int ALPHA_SIZE = 66;
    localparam int ALPHA_IDX_W = 7;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_KEY_INDICES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 2'd1;

    // special codes
    localparam logic [BYTE_W-1:0] CODE_NEWLINE  = 8'd10;
    localparam logic [BYTE_W-1:0] CODE_UPPER_YO = 8'hA8;
    localparam logic [BYTE_W-1:0] CODE_LOWER_YO = 8'hB8;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [KEY_IDX_W-1:0]   key_idx_t;
    typedef logic [ALPHA_IDX_W-1:0] alpha_idx_t;
    typedef logic [MAX_KEY_LEN-1:0][KEY_IDX_W-1:0] key_set_t;

    // letter at each alphabet index, uppercase block then lowercase block
    localparam byte_t ALPHA_TABLE [ALPHA_SIZE] = '{
        8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hA8, 8'hC6, 8'hC7, 8'hC8, 8'hC9,
        8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD4,
        8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF,
        8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hB8, 8'hE6, 8'hE7, 8'hE8, 8'hE9,
        8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4,
        8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic       is_letter;
        alpha_idx_t idx;
    } letter_t;

    // alphabet index of a byte, or not a letter
    function automatic letter_t letter_index(byte_t b);
        letter_t r;
        r.is_letter = 1'b1;
        r.idx       = '0;
        if (b == CODE_UPPER_YO) begin
            r.idx = 7'd6;
        end else if (b == CODE_LOWER_YO) begin
            r.idx = 7'd39;
        end else if (b >= 8'hE6) begin
            r.idx = ALPHA_IDX_W'(b - 8'd190);
        end else if (b >= 8'hE0) begin
            r.idx = ALPHA_IDX_W'(b - 8'd191);
        end else if (b >= 8'hC6) begin
            r.idx = ALPHA_IDX_W'(b - 8'd191);
        end else if (b >= 8'hC0) begin
            r.idx = ALPHA_IDX_W'(b - 8'd192);
        end else begin
            r.is_letter = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/cvenc_if.sv @@
// plaintext channel
interface cvenc_in_if;
    logic                    valid;
    logic                    ready;
    logic [cvenc_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ciphertext channel
interface cvenc_out_if;
    logic                    valid;
    logic                    ready;
    logic [cvenc_pkg::BYTE_W-1:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// register write channel
interface cvenc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cvenc_pkg::CFG_IDX_W-1:0]  index;
    logic [cvenc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cyrillic_vigenere_encrypt.sv @@
// Cyrillic Vigenere encryptor for a CP1251 byte stream.
// plain  : sink of plaintext bytes (valid/ready, in_byte)
// cipher : source of ciphertext bytes (valid/ready, out_byte), one per input beat
// cfg    : register writes, always ready; index 0 loads eight 7-bit key letters
//          (first letter lowest), index 1 loads the key length (1..8)
// Letters of the 66-letter alphabet are shifted by the current key letter minus one,
// other bytes are copied. Every byte but newline advances the key position.
// Each byte passes the input register, then the result register, before it
// appears on cipher. Throughput: one byte per cycle while cipher is ready,
// set by the two-stage pipeline with the key position updated at acceptance.
// When cipher stalls, the result register holds and the input stage keeps
// taking one more byte; plain.ready drops once both stages are full.
// Reset clears both stages and the key position, loads an all-zero key and a
// key length of one. Write registers only while the pipeline is empty.
module cyrillic_vigenere_encrypt (
    input  logic              clk,
    input  logic              rst_n,
    cvenc_in_if.sink          plain,
    cvenc_out_if.source       cipher,
    cvenc_cfg_if.sink         cfg
);

    cvenc_pkg::key_set_t                    key_set_reg;
    logic [cvenc_pkg::KEY_LEN_W-1:0]        key_len_reg;
    logic [cvenc_pkg::KEY_POS_W-1:0]        key_pos_reg;
    logic [cvenc_pkg::KEY_POS_W-1:0]        key_pos_next;

    logic                                   s0_valid_reg;
    cvenc_pkg::byte_t                       s0_byte_reg;
    cvenc_pkg::alpha_idx_t                  s0_key_reg;

    logic                                   out_valid_reg;
    cvenc_pkg::byte_t                       out_byte_reg;
    cvenc_pkg::byte_t                       out_byte_next;

    logic                                   out_free;
    logic                                   s0_adv;
    logic                                   in_beat;

    cvenc_pkg::key_idx_t                    key_raw;
    cvenc_pkg::alpha_idx_t                  key_red;
    logic [cvenc_pkg::KEY_POS_W:0]          pos_inc;
    logic [cvenc_pkg::KEY_LEN_W-1:0]        eff_len;

    cvenc_pkg::letter_t                     letter;
    logic [cvenc_pkg::ALPHA_IDX_W:0]        sum;
    logic [cvenc_pkg::ALPHA_IDX_W:0]        sum_m1;
    cvenc_pkg::alpha_idx_t                  out_idx;

    // handshakes
    assign out_free    = !out_valid_reg || cipher.ready;
    assign s0_adv      = s0_valid_reg && out_free;
    assign plain.ready = !s0_valid_reg || out_free;
    assign in_beat     = plain.valid && plain.ready;
    assign cfg.ready   = 1'b1;

    assign cipher.valid    = out_valid_reg;
    assign cipher.out_byte = out_byte_reg;

    // key letter at the current position, reduced below the alphabet size
    always_comb
    begin
        key_raw = key_set_reg[key_pos_reg];
        if (key_raw >= cvenc_pkg::KEY_IDX_W'(cvenc_pkg::ALPHA_SIZE)) begin
            key_red = cvenc_pkg::ALPHA_IDX_W'(key_raw
                      - cvenc_pkg::KEY_IDX_W'(cvenc_pkg::ALPHA_SIZE));
        end else begin
            key_red = cvenc_pkg::ALPHA_IDX_W'(key_raw);
        end
    end

    // key position advance, wrapping at the clamped key length
    always_comb
    begin
        eff_len = key_len_reg;
        if (key_len_reg == '0) begin
            eff_len = cvenc_pkg::KEY_LEN_W'(1);
        end else if (key_len_reg > cvenc_pkg::KEY_LEN_W'(cvenc_pkg::MAX_KEY_LEN)) begin
            eff_len = cvenc_pkg::KEY_LEN_W'(cvenc_pkg::MAX_KEY_LEN);
        end
        pos_inc = {1'b0, key_pos_reg} + 1'b1;
        if (cvenc_pkg::KEY_LEN_W'(pos_inc) >= eff_len) begin
            key_pos_next = '0;
        end else begin
            key_pos_next = pos_inc[cvenc_pkg::KEY_POS_W-1:0];
        end
    end

    // shift a letter by the key letter minus one, modulo the alphabet; copy other bytes
    always_comb
    begin
        letter = cvenc_pkg::letter_index(s0_byte_reg);
        sum    = {1'b0, letter.idx} + {1'b0, s0_key_reg};
        sum_m1 = sum - 1'b1;
        if (sum == '0) begin
            out_idx = cvenc_pkg::ALPHA_IDX_W'(cvenc_pkg::ALPHA_SIZE - 1);
        end else if (sum_m1 >= (cvenc_pkg::ALPHA_IDX_W + 1)'(cvenc_pkg::ALPHA_SIZE)) begin
            out_idx = cvenc_pkg::ALPHA_IDX_W'(sum_m1
                      - (cvenc_pkg::ALPHA_IDX_W + 1)'(cvenc_pkg::ALPHA_SIZE));
        end else begin
            out_idx = sum_m1[cvenc_pkg::ALPHA_IDX_W-1:0];
        end
        if (letter.is_letter) begin
            out_byte_next = cvenc_pkg::ALPHA_TABLE[out_idx];
        end else begin
            out_byte_next = s0_byte_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_set_reg <= '0;
            key_len_reg <= cvenc_pkg::KEY_LEN_W'(1);
        end else if (cfg.valid) begin
            unique case (cfg.index)
                cvenc_pkg::REG_KEY_INDICES: key_set_reg <= cfg.data;
                cvenc_pkg::REG_KEY_LENGTH:
                    key_len_reg <= cfg.data[cvenc_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // key position, stepped on every accepted beat but newline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_pos_reg <= '0;
        end else if (in_beat && plain.in_byte != cvenc_pkg::CODE_NEWLINE) begin
            key_pos_reg <= key_pos_next;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end else if (plain.ready) begin
            s0_valid_reg <= plain.valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_beat) begin
            s0_byte_reg <= plain.in_byte;
            s0_key_reg  <= key_red;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s0_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (s0_adv) begin
            out_byte_reg <= out_byte_next;
        end
    end

endmodule

@@ tb/cvenc_cipher_checker.sv @@
`timescale 1ns / 100ps

module cvenc_cipher_checker
    import cvenc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cvenc_in_if   plain,
    cvenc_out_if  cipher,
    cvenc_cfg_if  cfg,
    output int    errors,
    output int    pending
);

    // shadow of the key registers and the running key position
    key_set_t             key_set;
    logic [KEY_LEN_W-1:0] key_len;
    logic [KEY_POS_W-1:0] key_pos;

    // ciphertext bytes still owed by the block, oldest first
    byte_t cipher_due[$];

    // shift a letter by key letter k, copy anything else
    function automatic byte_t encipher(byte_t b, key_idx_t k);
        int letter;
        int shifted;
        letter = -1;
        for (int i = 0; i < ALPHA_SIZE; i++) begin
            if (ALPHA_TABLE[i] == b) begin
                letter = i;
            end
        end
        if (letter < 0) begin
            return b;
        end
        // sum of zero wraps to the last letter, oversized keys reduce mod 66
        shifted = (letter + int'(k) + ALPHA_SIZE - 1) % ALPHA_SIZE;
        return ALPHA_TABLE[shifted];
    endfunction

    // advance the key position; length 0 acts as 1, above the max saturates
    function automatic logic [KEY_POS_W-1:0] next_position(logic [KEY_POS_W-1:0] pos,
                                                          logic [KEY_LEN_W-1:0] len);
        int span;
        int step;
        if (len == 0) begin
            span = 1;
        end else if (len > MAX_KEY_LEN) begin
            span = MAX_KEY_LEN;
        end else begin
            span = int'(len);
        end
        step = int'(pos) + 1;
        return (step >= span) ? '0 : KEY_POS_W'(step);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // watch all three channels at each edge
    always @(posedge clk) begin : watch
        byte_t want;
        if (!rst_n) begin
            key_set = '0;
            key_len = KEY_LEN_W'(1);
            key_pos = '0;
            errors  = 0;
            cipher_due.delete();
        end else begin
            // register write beat
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_KEY_INDICES) begin
                    key_set = cfg.data;
                end else if (cfg.index == REG_KEY_LENGTH) begin
                    key_len = cfg.data[KEY_LEN_W-1:0];
                end
            end
            // plaintext beat: predict its ciphertext
            if (plain.valid && plain.ready) begin
                cipher_due.push_back(encipher(plain.in_byte, key_set[key_pos]));
                if (plain.in_byte != CODE_NEWLINE) begin
                    key_pos = next_position(key_pos, key_len);
                end
            end
            // ciphertext beat: compare with the oldest prediction
            if (cipher.valid && cipher.ready) begin
                if (cipher_due.size() == 0) begin
                    report_mismatch($sformatf("out_byte %02h with nothing outstanding",
                                              cipher.out_byte));
                end else begin
                    want = cipher_due.pop_front();
                    if (cipher.out_byte !== want) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  cipher.out_byte, want));
                    end
                end
            end
        end
        pending <= cipher_due.size();
    end

endmodule

@@ tb/cyrillic_vigenere_encrypt_test.sv @@
`timescale 1ns / 100ps

module cyrillic_vigenere_encrypt_test;
    import cvenc_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 65;
    localparam int IDLE_PERCENT  = 35;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    logic hold_req;
    int   errors;
    int   pending;
    int   quiet;

    cvenc_in_if  plain ();
    cvenc_out_if cipher ();
    cvenc_cfg_if cfg ();

    cyrillic_vigenere_encrypt i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .plain  (plain),
        .cipher (cipher),
        .cfg    (cfg)
    );

    cvenc_cipher_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .plain   (plain),
        .cipher  (cipher),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    always #5 clk = ~clk;

    // ciphertext receiver: random stalls, one long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left   = 0;
        hold_taken  = 1'b0;
        cipher.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                cipher.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_taken) begin
                cipher.ready <= 1'b0;
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end else begin
                cipher.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // end the run if no beat moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (plain.valid && plain.ready) || (cipher.valid && cipher.ready)
            || (cfg.valid && cfg.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // mostly letters, some yo, newlines and arbitrary bytes
    function automatic byte_t plaintext_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return CODE_NEWLINE;
        end else if (pick < 11) begin
            return CODE_UPPER_YO;
        end else if (pick < 14) begin
            return CODE_LOWER_YO;
        end else if (pick < 75) begin
            return byte_t'($urandom_range(8'hFF, 8'hC0));
        end
        return byte_t'($urandom_range(255));
    endfunction

    task automatic send_byte(byte_t b);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            plain.valid <= 1'b0;
            @(posedge clk);
        end
        plain.valid   <= 1'b1;
        plain.in_byte <= b;
        do @(posedge clk); while (!plain.ready);
    endtask

    // stop offering and wait until every predicted byte has come out
    task automatic drain();
        plain.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        key_set_t    ks;
        logic [63:0] wide;
        int          len;
        rst_n         = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        plain.valid   = 1'b0;
        plain.in_byte = '0;
        cfg.valid     = 1'b0;
        cfg.index     = '0;
        cfg.data      = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: byte extremes, yo, the wrap of the first letter, newline
        send_byte(8'hC0);
        send_byte(8'hFF);
        send_byte(CODE_UPPER_YO);
        send_byte(CODE_LOWER_YO);
        send_byte(8'h00);
        send_byte(CODE_NEWLINE);
        send_byte(8'hBF);
        send_byte(8'hDF);
        send_byte(8'hE0);
        send_byte(8'h80);
        drain();

        // full-length key with oversized key letters
        write_reg(REG_KEY_INDICES, key_set_t'({7'd39, 7'd6, 7'd33, 7'd0,
                                               7'd127, 7'd66, 7'd65, 7'd1}));
        write_reg(REG_KEY_LENGTH, CFG_DATA_W'(MAX_KEY_LEN));
        send_byte(8'hC0);
        send_byte(8'hFF);
        send_byte(CODE_NEWLINE);
        send_byte(8'hC5);
        send_byte(CODE_UPPER_YO);
        send_byte(8'hE5);
        send_byte(CODE_LOWER_YO);
        send_byte(8'hE6);
        drain();

        // shorten the key while the position sits past the new length
        write_reg(REG_KEY_LENGTH, CFG_DATA_W'(3));
        send_byte(8'hD0);
        send_byte(CODE_NEWLINE);
        send_byte(8'hE0);
        send_byte(8'hF3);

        // random phases, each with its own key setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            wide = {$urandom(), $urandom()};
            ks   = wide[CFG_DATA_W-1:0];
            len  = ($urandom_range(3) == 0) ? $urandom_range(15)
                                            : $urandom_range(MAX_KEY_LEN, 1);
            case (p)
                0: begin
                    ks  = '1;
                    len = MAX_KEY_LEN;
                end
                1: begin
                    ks  = '0;
                    len = 15;
                end
                2: len = 0;
                3: len = 1;
                4: write_reg(REG_SPARE, wide[CFG_DATA_W-1:0]);
                default: ;
            endcase
            write_reg(REG_KEY_INDICES, ks);
            write_reg(REG_KEY_LENGTH, CFG_DATA_W'(len));
            steady   <= (p == 5);
            hold_req <= (p == 7);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_byte(plaintext_byte());
            end
        end
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
